[rtl/plq_pkg.sv]
package plq_pkg;

    localparam int ENTRIES    = 1024;
    localparam int VALUE_BITS = 32;
    localparam int SLOT_W     = $clog2(ENTRIES);
    localparam int PTR_W      = SLOT_W + 1;

    typedef logic [1:0]                   t_mode;
    typedef logic signed [VALUE_BITS-1:0] t_value;
    typedef logic [SLOT_W-1:0]            t_slot;
    typedef logic [PTR_W-1:0]             t_ptr;

    localparam t_ptr NIL       = t_ptr'(ENTRIES);
    localparam t_ptr CAP_RESET = t_ptr'(ENTRIES);

    localparam t_mode MODE_APPEND = 2'd0;
    localparam t_mode MODE_POP    = 2'd1;
    localparam t_mode MODE_REMOVE = 2'd2;

endpackage

[rtl/plq_if.sv]
interface plq_in_if;
    import plq_pkg::*;

    logic   valid;
    logic   ready;
    t_mode  mode;
    t_value value;
    t_slot  slot_id;

    modport source (output valid, output mode, output value, output slot_id, input ready);
    modport sink (input valid, input mode, input value, input slot_id, output ready);
endinterface

interface plq_out_if;
    import plq_pkg::*;

    logic  valid;
    logic  ready;
    logic  ok;
    t_slot result_slot;
    t_ptr  live_count;

    modport source (output valid, output ok, output result_slot, output live_count, input ready);
    modport sink (input valid, input ok, input result_slot, input live_count, output ready);
endinterface

[rtl/plq_ram.sv]
module plq_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 11
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/pooled_linked_queue_manager.sv]
// a result is registered at the end of the execute state
// no new operation is taken while one executes; the link, in-use and free-stack
// memories are read in the accept cycle and written in the execute cycle
// a waiting result holds the execute cycle until the output beat is taken
// reset (i_rst_n, synchronous, active low): empty list, empty free stack,
// capacity 1024; no memory clearing pass is needed
module pooled_linked_queue_manager (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  plq_pkg::t_ptr i_cfg_wdata,
    plq_in_if.sink        i_in,
    plq_out_if.source     o_out
);
    import plq_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic   r_state, n_state;
    t_mode  r_mode;
    t_value r_value;
    t_slot  r_sid;

    t_ptr r_cap, r_free_top, n_free_top, r_fresh, n_fresh;
    t_ptr r_head, n_head, r_tail, n_tail, r_count, n_count;

    logic  r_out_valid, r_out_ok, n_ok;
    t_slot r_out_slot, n_slot;
    t_ptr  r_out_count;

    logic  accept, go;
    t_ptr  eff_cap;

    logic  next_we, prev_we, use_we, use_wdata, free_we, val_we;
    t_slot next_waddr, prev_waddr, use_waddr, use_raddr, next_raddr, free_raddr;
    t_ptr  next_wdata, prev_wdata, next_rdata, prev_rdata;
    logic  use_rdata;
    t_slot free_rdata;
    t_slot s;
    logic  release_s;

    assign accept  = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == S_IDLE);
    assign go      = (r_state == S_EXEC) && (!r_out_valid || o_out.ready);
    assign eff_cap = (r_cap > NIL) ? NIL : r_cap;

    assign use_raddr  = i_in.slot_id;
    assign next_raddr = (i_in.mode == MODE_POP) ? r_head[SLOT_W-1:0] : i_in.slot_id;
    assign free_raddr = SLOT_W'(r_free_top - t_ptr'(1));

    always_comb begin
        n_state    = r_state;
        n_free_top = r_free_top;
        n_fresh    = r_fresh;
        n_head     = r_head;
        n_tail     = r_tail;
        n_count    = r_count;
        n_ok       = 1'b0;
        n_slot     = '0;
        s          = '0;
        release_s  = 1'b0;
        next_we    = 1'b0;
        next_waddr = '0;
        next_wdata = NIL;
        prev_we    = 1'b0;
        prev_waddr = '0;
        prev_wdata = NIL;
        use_we     = 1'b0;
        use_waddr  = '0;
        use_wdata  = 1'b0;
        free_we    = 1'b0;
        val_we     = 1'b0;

        if (r_state == S_IDLE) begin
            if (accept) begin
                n_state = S_EXEC;
            end
        end else if (go) begin
            n_state = S_IDLE;
            case (r_mode)
                MODE_APPEND: begin
                    if (r_free_top != '0) begin
                        s          = free_rdata;
                        n_free_top = r_free_top - t_ptr'(1);
                        n_ok       = 1'b1;
                    end else if (r_fresh < eff_cap) begin
                        s       = r_fresh[SLOT_W-1:0];
                        n_fresh = r_fresh + t_ptr'(1);
                        n_ok    = 1'b1;
                    end
                    if (n_ok) begin
                        val_we     = 1'b1;
                        use_we     = 1'b1;
                        use_waddr  = s;
                        use_wdata  = 1'b1;
                        prev_we    = 1'b1;
                        prev_waddr = s;
                        if (r_count == '0) begin
                            prev_wdata = NIL;
                            n_head     = {1'b0, s};
                        end else begin
                            prev_wdata = r_tail;
                            next_we    = !r_tail[SLOT_W];
                            next_waddr = r_tail[SLOT_W-1:0];
                            next_wdata = {1'b0, s};
                        end
                        n_tail  = {1'b0, s};
                        n_count = r_count + t_ptr'(1);
                        n_slot  = s;
                    end
                end
                MODE_POP: begin
                    if (!r_head[SLOT_W]) begin
                        s         = r_head[SLOT_W-1:0];
                        n_ok      = 1'b1;
                        release_s = 1'b1;
                        if (r_count < t_ptr'(2)) begin
                            n_head = NIL;
                            n_tail = NIL;
                        end else begin
                            n_head     = next_rdata;
                            prev_we    = !next_rdata[SLOT_W];
                            prev_waddr = next_rdata[SLOT_W-1:0];
                            prev_wdata = NIL;
                        end
                    end
                end
                MODE_REMOVE: begin
                    if (({1'b0, r_sid} < eff_cap) && ({1'b0, r_sid} < r_fresh) && use_rdata) begin
                        s         = r_sid;
                        n_ok      = 1'b1;
                        release_s = 1'b1;
                        if (r_count < t_ptr'(2)) begin
                            n_head = NIL;
                            n_tail = NIL;
                        end else if ({1'b0, r_sid} == r_head) begin
                            n_head     = next_rdata;
                            prev_we    = !next_rdata[SLOT_W];
                            prev_waddr = next_rdata[SLOT_W-1:0];
                            prev_wdata = NIL;
                        end else if ({1'b0, r_sid} == r_tail) begin
                            n_tail     = prev_rdata;
                            next_we    = !prev_rdata[SLOT_W];
                            next_waddr = prev_rdata[SLOT_W-1:0];
                            next_wdata = NIL;
                        end else begin
                            next_we    = !prev_rdata[SLOT_W];
                            next_waddr = prev_rdata[SLOT_W-1:0];
                            next_wdata = next_rdata;
                            prev_we    = !next_rdata[SLOT_W];
                            prev_waddr = next_rdata[SLOT_W-1:0];
                            prev_wdata = prev_rdata;
                        end
                    end
                end
                default: begin
                    n_ok = 1'b0;
                end
            endcase

            if (release_s) begin
                use_we    = 1'b1;
                use_waddr = s;
                use_wdata = 1'b0;
                if (r_free_top < NIL) begin
                    free_we    = 1'b1;
                    n_free_top = r_free_top + t_ptr'(1);
                end
                if (r_count != '0) begin
                    n_count = r_count - t_ptr'(1);
                end
                n_slot = s;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cap       <= CAP_RESET;
            r_free_top  <= '0;
            r_fresh     <= '0;
            r_head      <= NIL;
            r_tail      <= NIL;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_free_top <= n_free_top;
            r_fresh    <= n_fresh;
            r_head     <= n_head;
            r_tail     <= n_tail;
            r_count    <= n_count;
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            if (go) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode  <= i_in.mode;
            r_value <= i_in.value;
            r_sid   <= i_in.slot_id;
        end
        if (go) begin
            r_out_ok    <= n_ok;
            r_out_slot  <= n_slot;
            r_out_count <= n_count;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.ok          = r_out_ok;
    assign o_out.result_slot = r_out_slot;
    assign o_out.live_count  = r_out_count;

    plq_ram #(.DEPTH(ENTRIES), .WIDTH(PTR_W)) u_next (
        .i_clk   (i_clk),
        .i_we    (next_we),
        .i_waddr (next_waddr),
        .i_wdata (next_wdata),
        .i_re    (accept),
        .i_raddr (next_raddr),
        .o_rdata (next_rdata)
    );

    plq_ram #(.DEPTH(ENTRIES), .WIDTH(PTR_W)) u_prev (
        .i_clk   (i_clk),
        .i_we    (prev_we),
        .i_waddr (prev_waddr),
        .i_wdata (prev_wdata),
        .i_re    (accept),
        .i_raddr (i_in.slot_id),
        .o_rdata (prev_rdata)
    );

    // entries at or above the fresh mark were never allocated and read as free
    plq_ram #(.DEPTH(ENTRIES), .WIDTH(1)) u_in_use (
        .i_clk   (i_clk),
        .i_we    (use_we),
        .i_waddr (use_waddr),
        .i_wdata (use_wdata),
        .i_re    (accept),
        .i_raddr (use_raddr),
        .o_rdata (use_rdata)
    );

    plq_ram #(.DEPTH(ENTRIES), .WIDTH(SLOT_W)) u_free (
        .i_clk   (i_clk),
        .i_we    (free_we),
        .i_waddr (r_free_top[SLOT_W-1:0]),
        .i_wdata (s),
        .i_re    (accept),
        .i_raddr (free_raddr),
        .o_rdata (free_rdata)
    );

    plq_ram #(.DEPTH(ENTRIES), .WIDTH(VALUE_BITS)) u_value (
        .i_clk   (i_clk),
        .i_we    (val_we),
        .i_waddr (s),
        .i_wdata (r_value),
        .i_re    (1'b0),
        .i_raddr (s),
        .o_rdata ()
    );

endmodule

[bench/tb.sv]
`timescale 1ns / 100ps

module tb;
    import plq_pkg::*;

    localparam t_mode MODE_UNUSED = 2'd3;
    localparam int    STALL_LIMIT = 4000;

    typedef struct packed {
        logic  ok;
        t_slot slot;
        t_ptr  live;
    } t_op_result;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we;
    t_ptr i_cfg_wdata;

    plq_in_if  in_bus ();
    plq_out_if out_bus ();

    pooled_linked_queue_manager u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_bus),
        .o_out       (out_bus)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // shadow of the pool
    t_ptr  next_of    [ENTRIES];
    t_ptr  prev_of    [ENTRIES];
    logic  slot_used  [ENTRIES];
    t_slot free_stack [ENTRIES];
    t_ptr  free_top;
    t_ptr  fresh_mark;
    t_ptr  head;
    t_ptr  tail;
    t_ptr  live_cnt;
    t_ptr  cap_shadow;

    t_op_result pending_results [$];

    bit idle_on;
    int ops_sent;
    int ops_refused;
    int results_checked;
    int mismatches;
    int cap_settings;
    int quiet_cycles;
    int stall_left;

    function automatic void release_slot(t_slot s);
        slot_used[s] = 1'b0;
        next_of[s]   = NIL;
        prev_of[s]   = NIL;
        if (free_top < NIL) begin
            free_stack[free_top[SLOT_W-1:0]] = s;
            free_top = free_top + 1'b1;
        end
        if (live_cnt != 0) begin
            live_cnt = live_cnt - 1'b1;
        end
    endfunction

    function automatic t_op_result apply_list_op(t_mode m, t_slot sid);
        t_op_result r;
        t_ptr       cap_eff;
        t_ptr       s;
        t_ptr       nx;
        t_ptr       pv;
        r       = '0;
        s       = NIL;
        cap_eff = (cap_shadow < NIL) ? cap_shadow : NIL;
        case (m)
            MODE_APPEND: begin
                if (free_top != 0) begin
                    free_top = free_top - 1'b1;
                    s = {1'b0, free_stack[free_top[SLOT_W-1:0]]};
                end else if (fresh_mark < cap_eff) begin
                    s = fresh_mark;
                    fresh_mark = fresh_mark + 1'b1;
                end
                if (s < NIL) begin
                    next_of[s[SLOT_W-1:0]] = NIL;
                    if (live_cnt == 0) begin
                        prev_of[s[SLOT_W-1:0]] = NIL;
                        head = s;
                    end else begin
                        if (tail < NIL) next_of[tail[SLOT_W-1:0]] = s;
                        prev_of[s[SLOT_W-1:0]] = tail;
                    end
                    tail = s;
                    slot_used[s[SLOT_W-1:0]] = 1'b1;
                    live_cnt = live_cnt + 1'b1;
                    r.ok   = 1'b1;
                    r.slot = s[SLOT_W-1:0];
                end
            end
            MODE_POP: begin
                if (head < NIL) begin
                    s = head;
                    if (live_cnt <= 1) begin
                        head = NIL;
                        tail = NIL;
                    end else begin
                        head = next_of[s[SLOT_W-1:0]];
                        if (head < NIL) prev_of[head[SLOT_W-1:0]] = NIL;
                    end
                    release_slot(s[SLOT_W-1:0]);
                    r.ok   = 1'b1;
                    r.slot = s[SLOT_W-1:0];
                end
            end
            MODE_REMOVE: begin
                if ({1'b0, sid} < cap_eff && slot_used[sid]) begin
                    nx = next_of[sid];
                    pv = prev_of[sid];
                    if (live_cnt <= 1) begin
                        head = NIL;
                        tail = NIL;
                    end else if ({1'b0, sid} == head) begin
                        head = nx;
                        if (nx < NIL) prev_of[nx[SLOT_W-1:0]] = NIL;
                    end else if ({1'b0, sid} == tail) begin
                        tail = pv;
                        if (pv < NIL) next_of[pv[SLOT_W-1:0]] = NIL;
                    end else begin
                        if (pv < NIL) next_of[pv[SLOT_W-1:0]] = nx;
                        if (nx < NIL) prev_of[nx[SLOT_W-1:0]] = pv;
                    end
                    release_slot(sid);
                    r.ok   = 1'b1;
                    r.slot = sid;
                end
            end
            default: ;
        endcase
        r.live = live_cnt;
        return r;
    endfunction

    // a random slot that is currently linked, found by walking from the head
    function automatic t_slot pick_linked_slot();
        t_ptr p;
        int   k;
        p = head;
        k = $urandom_range(0, live_cnt - 1);
        repeat (k) p = next_of[p[SLOT_W-1:0]];
        return p[SLOT_W-1:0];
    endfunction

    task automatic issue_op(t_mode m, t_value v, t_slot sid);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 9);
            in_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_bus.valid   <= 1'b1;
        in_bus.mode    <= m;
        in_bus.value   <= v;
        in_bus.slot_id <= sid;
        do @(posedge i_clk); while (!in_bus.ready);
        pending_results.insert(pending_results.size(), apply_list_op(m, sid));
        ops_sent++;
        if (!pending_results[$].ok) ops_refused++;
    endtask

    task automatic settle();
        in_bus.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_capacity(t_ptr c);
        settle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= c;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        cap_shadow  = c;
        cap_settings++;
    endtask

    task automatic test_basic_ops();
        idle_on = 1'b1;
        issue_op(MODE_POP, '0, '0);
        issue_op(MODE_REMOVE, '0, 10'd0);
        issue_op(MODE_UNUSED, '0, 10'd1023);
        issue_op(MODE_APPEND, t_value'(32'h8000_0000), '0);
        issue_op(MODE_APPEND, t_value'(32'h7fff_ffff), 10'd1023);
        issue_op(MODE_APPEND, t_value'(0), '0);
        issue_op(MODE_APPEND, t_value'(-1), '0);
        issue_op(MODE_APPEND, t_value'(5), '0);
        issue_op(MODE_REMOVE, '0, 10'd2);
        issue_op(MODE_REMOVE, '0, 10'd0);
        issue_op(MODE_REMOVE, '0, 10'd4);
        issue_op(MODE_REMOVE, '0, 10'd1023);
        issue_op(MODE_APPEND, t_value'(9), '0);
        issue_op(MODE_POP, '0, '0);
        issue_op(MODE_POP, '0, '0);
        issue_op(MODE_POP, '0, '0);
        issue_op(MODE_POP, '0, '0);
    endtask

    // pool shrunk below slots that are on the free stack and are then linked again
    task automatic test_capacity_edges();
        write_capacity(t_ptr'(1));
        repeat (6) issue_op(MODE_APPEND, t_value'($urandom), t_slot'($urandom));
        issue_op(MODE_REMOVE, '0, 10'd3);
        issue_op(MODE_POP, '0, '0);
    endtask

    task automatic test_random_mix(t_ptr cap, int n_ops, int fill_target, bit idle);
        t_mode m;
        t_slot sid;
        int    r;
        int    pa;
        int    hi;
        write_capacity(cap);
        idle_on = idle;
        repeat (n_ops) begin
            r   = $urandom_range(0, 99);
            pa  = (live_cnt < fill_target) ? 80 : 30;
            sid = t_slot'($urandom);
            if (r < 2) begin
                m = MODE_UNUSED;
            end else if (r < 2 + pa) begin
                m = MODE_APPEND;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 35) begin
                    m = MODE_POP;
                end else if (r < 80 && live_cnt != 0) begin
                    m   = MODE_REMOVE;
                    sid = pick_linked_slot();
                end else begin
                    m  = MODE_REMOVE;
                    hi = (cap < NIL) ? int'(cap) : ENTRIES - 1;
                    if ($urandom_range(0, 1) == 0) sid = t_slot'($urandom_range(0, hi));
                end
            end
            issue_op(m, t_value'($urandom), sid);
        end
    endtask

    // result side: random stall bursts
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left    <= stall_left - 1;
            out_bus.ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall_left    <= $urandom_range(0, 8);
            out_bus.ready <= 1'b0;
        end else begin
            out_bus.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_op_result want;
        if (i_rst_n && out_bus.valid && out_bus.ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result with none expected: ok=%0d slot=%0d live=%0d",
                         $time, out_bus.ok, out_bus.result_slot, out_bus.live_count);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                results_checked++;
                if (out_bus.ok !== want.ok) begin
                    $display("%0t: ok expected %0d actual %0d", $time, want.ok, out_bus.ok);
                    mismatches++;
                end
                if (out_bus.result_slot !== want.slot) begin
                    $display("%0t: result_slot expected %0d actual %0d",
                             $time, want.slot, out_bus.result_slot);
                    mismatches++;
                end
                if (out_bus.live_count !== want.live) begin
                    $display("%0t: live_count expected %0d actual %0d",
                             $time, want.live, out_bus.live_count);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no beat moved for %0d cycles", $time, quiet_cycles);
            $display("end of test: mismatches");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        in_bus.valid   = 1'b0;
        in_bus.mode    = MODE_APPEND;
        in_bus.value   = '0;
        in_bus.slot_id = '0;
        i_cfg_we       = 1'b0;
        i_cfg_wdata    = '0;
        idle_on        = 1'b0;
        free_top       = '0;
        fresh_mark     = '0;
        head           = NIL;
        tail           = NIL;
        live_cnt       = '0;
        cap_shadow     = CAP_RESET;
        foreach (slot_used[i]) slot_used[i] = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_basic_ops();
        test_capacity_edges();
        test_random_mix(t_ptr'(4),    150,   4, 1'b1);
        test_random_mix(t_ptr'(1),     60,   1, 1'b1);
        test_random_mix(t_ptr'(37),   200,  30, 1'b0);
        test_random_mix(t_ptr'(300),  300, 250, 1'b1);
        test_random_mix(t_ptr'(16),   150,  10, 1'b1);
        test_random_mix(t_ptr'(0),     80,   5, 1'b1);
        test_random_mix(t_ptr'(2047), 200,  60, 1'b1);
        test_random_mix(CAP_RESET,    150,  20, 1'b1);
        test_random_mix(t_ptr'(8),    240,   6, 1'b0);
        settle();
        repeat (8) @(posedge i_clk);

        $display("covered %0d operations (%0d refused) over %0d capacity settings",
                 ops_sent, ops_refused, cap_settings);
        $display("%0d results checked, %0d field mismatches", results_checked, mismatches);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/plq_pkg.sv
rtl/plq_if.sv
rtl/plq_ram.sv
rtl/pooled_linked_queue_manager.sv
bench/tb.sv
